/* hdl/cfthp_pkg.sv */
// package: shared types and constants for the tcp header parser
package cfthp_pkg;

    localparam int MAX_FRAME_BYTES = 65535;

    typedef enum logic [2:0] {
        PH_LINK = 3'd0,
        PH_VLAN = 3'd1,
        PH_IP4  = 3'd2,
        PH_IP6  = 3'd3,
        PH_EXT  = 3'd4,
        PH_TCP  = 3'd5,
        PH_PAY  = 3'd6
    } t_phase;

    localparam logic [2:0] V_TCP       = 3'd0;
    localparam logic [2:0] V_TRUNC     = 3'd1;
    localparam logic [2:0] V_BAD_LINK  = 3'd2;
    localparam logic [2:0] V_NOT_IP    = 3'd3;
    localparam logic [2:0] V_NOT_TCP   = 3'd4;
    localparam logic [2:0] V_BAD_HLEN  = 3'd5;
    localparam logic [2:0] V_NO_PAY    = 3'd6;

    localparam logic [2:0] LK_ETH  = 3'd0;
    localparam logic [2:0] LK_SLL2 = 3'd1;
    localparam logic [2:0] LK_SLL  = 3'd2;
    localparam logic [2:0] LK_NULL = 3'd3;
    localparam logic [2:0] LK_RAW  = 3'd4;

    localparam logic [15:0] ET_VLAN = 16'h8100;
    localparam logic [15:0] ET_QINQ = 16'h88A8;
    localparam logic [15:0] ET_IP4  = 16'h0800;
    localparam logic [15:0] ET_IP6  = 16'h86DD;

    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] TLS_HS   = 8'h16;

    localparam logic [0:0] REG_LINK_KIND = 1'b0;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [2:0]  ip_ver;
        logic [63:0] sa_hi;
        logic [63:0] sa_lo;
        logic [63:0] da_hi;
        logic [63:0] da_lo;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [15:0] off;
        logic [15:0] plen;
        logic        hs;
    } t_result;

endpackage

/* hdl/cfthp_cfg.sv */
// module: apb register block holding the link kind
module cfthp_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  o_link_kind
);
    logic [2:0] r_link_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind <= '0;
        end else if (psel && penable && pwrite && paddr == cfthp_pkg::REG_LINK_KIND) begin
            r_link_kind <= pwdata[2:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr == cfthp_pkg::REG_LINK_KIND) ? {29'd0, r_link_kind} : 32'd0;
    assign o_link_kind = r_link_kind;
endmodule

/* hdl/cfthp_parse.sv */
// module: per-byte header parsing state and result formation
module cfthp_parse #(
    parameter int MAX_FRAME_BYTES = cfthp_pkg::MAX_FRAME_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  logic [2:0]          i_link_kind,
    output logic                o_done,
    output cfthp_pkg::t_result  o_res
);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    cfthp_pkg::t_phase r_ph, n_ph;
    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_et, n_et;
    logic [PW-1:0] r_ss, n_ss;
    logic [15:0]   r_sl, n_sl;
    logic [7:0]    r_np, n_np;
    logic [63:0]   r_a [4];
    logic [63:0]   n_a [4];
    logic [63:0]   r_ps, n_ps;
    logic [2:0]    r_cm, n_cm;
    logic [2:0]    r_err, n_err;
    logic [2:0]    r_fk, n_fk;
    logic [2:0]    r_iv, n_iv;
    logic          r_h1, n_h1, r_h7, n_h7;

    logic [PW-1:0] rel, p1, plen, off;
    logic [31:0]   seq;
    logic          hs, strip;
    logic [2:0]    fk;
    logic          pe;

    always_comb begin
        n_ph = r_ph; n_pos = r_pos; n_et = r_et; n_ss = r_ss; n_sl = r_sl;
        n_np = r_np; n_a = r_a; n_ps = r_ps; n_cm = r_cm; n_err = r_err;
        n_fk = r_fk; n_iv = r_iv; n_h1 = r_h1; n_h7 = r_h7;
        p1 = r_pos + PW'(1);
        fk = r_fk;
        pe = 1'b0;
        rel = '0;
        if (r_pos < PW'(MAX_FRAME_BYTES)) begin
            if (r_pos == '0) begin
                fk = i_link_kind;
                n_fk = fk;
                if (fk > cfthp_pkg::LK_RAW) n_err = cfthp_pkg::V_BAD_LINK;
                else if (fk == cfthp_pkg::LK_RAW) begin
                    n_ss = '0;
                    if (i_byte[7:4] == 4'd4) begin
                        n_ph = cfthp_pkg::PH_IP4; n_sl = 16'd20; n_iv = 3'd4;
                    end else begin
                        n_ph = cfthp_pkg::PH_IP6; n_sl = 16'd40; n_iv = 3'd6;
                    end
                end
            end
            rel = r_pos - n_ss;
            if (n_err == '0) begin
                case (n_ph)
                    cfthp_pkg::PH_LINK: begin
                        if (fk == cfthp_pkg::LK_ETH) begin
                            if (rel == PW'(12)) n_et = {i_byte, 8'd0};
                            if (rel == PW'(13)) begin n_et = {r_et[15:8], i_byte}; pe = 1'b1; end
                        end else if (fk == cfthp_pkg::LK_SLL2) begin
                            if (rel == PW'(0)) n_et = {i_byte, 8'd0};
                            if (rel == PW'(1)) n_et = {r_et[15:8], i_byte};
                            if (rel == PW'(19)) pe = 1'b1;
                        end else if (fk == cfthp_pkg::LK_SLL) begin
                            if (rel == PW'(14)) n_et = {i_byte, 8'd0};
                            if (rel == PW'(15)) begin n_et = {r_et[15:8], i_byte}; pe = 1'b1; end
                        end else begin
                            if (rel == PW'(0))
                                n_et = (i_byte == 8'd2) ? cfthp_pkg::ET_IP4 : cfthp_pkg::ET_IP6;
                            else if (i_byte != 8'd0) n_et = cfthp_pkg::ET_IP6;
                            if (rel == PW'(3)) pe = 1'b1;
                        end
                    end
                    cfthp_pkg::PH_VLAN: begin
                        if (rel == PW'(2)) n_et = {i_byte, 8'd0};
                        if (rel == PW'(3)) begin n_et = {r_et[15:8], i_byte}; pe = 1'b1; end
                    end
                    cfthp_pkg::PH_IP4: begin
                        if (rel == PW'(0) && i_byte[7:4] != 4'd4) n_err = cfthp_pkg::V_NOT_IP;
                        else if (rel == PW'(0) && i_byte[3:0] < 4'd5) n_err = cfthp_pkg::V_BAD_HLEN;
                        else if (rel == PW'(9) && i_byte != cfthp_pkg::NH_TCP)
                            n_err = cfthp_pkg::V_NOT_TCP;
                        else begin
                            if (rel == PW'(0)) n_sl = 16'({i_byte[3:0], 2'b00});
                            if (rel >= PW'(12) && rel < PW'(16))
                                n_a[1] = {32'd0, r_a[1][23:0], i_byte};
                            if (rel >= PW'(16) && rel < PW'(20))
                                n_a[3] = {32'd0, r_a[3][23:0], i_byte};
                            if (rel + PW'(1) == n_sl) begin
                                n_ph = cfthp_pkg::PH_TCP; n_ss = p1; n_sl = 16'd20;
                            end
                        end
                    end
                    cfthp_pkg::PH_IP6: begin
                        if (rel == PW'(0) && i_byte[7:4] != 4'd6) n_err = cfthp_pkg::V_NOT_IP;
                        else begin
                            if (rel == PW'(6)) n_np = i_byte;
                            if (rel >= PW'(8) && rel < PW'(40))
                                n_a[rel[4:3] - 2'd1] = {r_a[rel[4:3] - 2'd1][55:0], i_byte};
                            if (rel == PW'(39)) begin
                                if (r_np == cfthp_pkg::NH_HOP || r_np == cfthp_pkg::NH_ROUTE) begin
                                    n_ph = cfthp_pkg::PH_EXT; n_ss = p1; n_sl = 16'd8;
                                end else if (r_np != cfthp_pkg::NH_TCP)
                                    n_err = cfthp_pkg::V_NOT_TCP;
                                else begin
                                    n_ph = cfthp_pkg::PH_TCP; n_ss = p1; n_sl = 16'd20;
                                end
                            end
                        end
                    end
                    cfthp_pkg::PH_EXT: begin
                        if (rel == PW'(0)) n_np = i_byte;
                        if (rel == PW'(1)) n_sl = 16'({3'd0, i_byte, 3'd0} + 14'd8);
                        if (rel + PW'(1) == n_sl) begin
                            if (n_np == cfthp_pkg::NH_HOP || n_np == cfthp_pkg::NH_ROUTE) begin
                                n_ph = cfthp_pkg::PH_EXT; n_ss = p1; n_sl = 16'd8;
                            end else if (n_np != cfthp_pkg::NH_TCP)
                                n_err = cfthp_pkg::V_NOT_TCP;
                            else begin
                                n_ph = cfthp_pkg::PH_TCP; n_ss = p1; n_sl = 16'd20;
                            end
                        end
                    end
                    cfthp_pkg::PH_TCP: begin
                        if (rel < PW'(8)) n_ps = {r_ps[55:0], i_byte};
                        if (rel == PW'(12) && i_byte[7:4] < 4'd5) n_err = cfthp_pkg::V_BAD_HLEN;
                        else begin
                            if (rel == PW'(12)) n_sl = 16'({i_byte[7:4], 2'b00});
                            if (rel + PW'(1) == n_sl) begin
                                n_ph = cfthp_pkg::PH_PAY; n_ss = p1; n_sl = '0; n_cm = '0;
                            end
                        end
                    end
                    default: begin
                        if (rel < PW'(5)) begin
                            if (r_cm == rel[2:0] && i_byte == (rel == PW'(0) ? 8'h14 :
                                rel == PW'(3) ? 8'h00 : rel == PW'(4) ? 8'h01 : 8'h03))
                                n_cm = rel[2:0] + 3'd1;
                            else n_cm = 3'd7;
                        end
                        if (rel == PW'(0)) n_h1 = (i_byte == cfthp_pkg::TLS_HS);
                        if (rel == PW'(6)) n_h7 = (i_byte == cfthp_pkg::TLS_HS);
                    end
                endcase
                if (pe) begin
                    if (fk == cfthp_pkg::LK_ETH &&
                        (n_et == cfthp_pkg::ET_VLAN || n_et == cfthp_pkg::ET_QINQ)) begin
                        n_ph = cfthp_pkg::PH_VLAN; n_ss = p1; n_sl = 16'd4;
                    end else if (n_et == cfthp_pkg::ET_IP4) begin
                        n_ph = cfthp_pkg::PH_IP4; n_ss = p1; n_sl = 16'd20; n_iv = 3'd4;
                    end else if (n_et == cfthp_pkg::ET_IP6) begin
                        n_ph = cfthp_pkg::PH_IP6; n_ss = p1; n_sl = 16'd40; n_iv = 3'd6;
                    end else n_err = cfthp_pkg::V_NOT_IP;
                end
            end
            n_pos = p1;
        end
    end

    // result from the updated state
    always_comb begin
        plen  = n_pos - n_ss;
        off   = n_ss;
        seq   = n_ps[31:0];
        hs    = n_h1;
        strip = (plen >= PW'(6)) && (n_cm == 3'd5);
        if (strip) begin
            plen = plen - PW'(6);
            off  = off + PW'(6);
            seq  = seq + 32'd6;
            hs   = n_h7;
        end
        o_res = '0;
        if (n_err != '0) o_res.verdict = n_err;
        else if (n_ph != cfthp_pkg::PH_PAY) o_res.verdict = cfthp_pkg::V_TRUNC;
        else begin
            o_res.verdict    = (plen == '0) ? cfthp_pkg::V_NO_PAY : cfthp_pkg::V_TCP;
            o_res.ip_ver     = n_iv;
            o_res.sa_hi = n_a[0]; o_res.sa_lo = n_a[1];
            o_res.da_hi = n_a[2]; o_res.da_lo = n_a[3];
            o_res.sport = n_ps[63:48]; o_res.dport = n_ps[47:32];
            o_res.seq   = seq;
            o_res.off   = 16'(off);
            o_res.plen  = 16'(plen);
            o_res.hs    = (plen != '0) && hs;
        end
    end

    assign o_done = i_take && i_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_done) begin
            r_ph <= cfthp_pkg::PH_LINK; r_pos <= '0; r_et <= '0; r_ss <= '0; r_sl <= '0;
            r_np <= '0; r_a <= '{default: '0}; r_ps <= '0; r_cm <= '0; r_err <= '0;
            r_fk <= '0; r_iv <= '0; r_h1 <= 1'b0; r_h7 <= 1'b0;
        end else if (i_take) begin
            r_ph <= n_ph; r_pos <= n_pos; r_et <= n_et; r_ss <= n_ss; r_sl <= n_sl;
            r_np <= n_np; r_a <= n_a; r_ps <= n_ps; r_cm <= n_cm; r_err <= n_err;
            r_fk <= n_fk; r_iv <= n_iv; r_h1 <= n_h1; r_h7 <= n_h7;
        end
    end
endmodule

/* hdl/capture_frame_tcp_header_parser.sv */
// top level: streaming link, ip and tcp header parser for captured frames
// One frame byte is taken per cycle unless o_stall holds it; a request ends at the byte
// marked frame end, and its single result appears in the output register in the next cycle.
// The byte-wide parse state update is the only loop. A new byte is accepted while a result
// waits unless the output register is full and stalled.
module capture_frame_tcp_header_parser #(
    parameter int MAX_FRAME_BYTES = cfthp_pkg::MAX_FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_verdict,
    output logic [2:0]  o_ip_ver,
    output logic [63:0] o_source_addr_high,
    output logic [63:0] o_source_addr_low,
    output logic [63:0] o_dest_addr_high,
    output logic [63:0] o_dest_addr_low,
    output logic [15:0] o_source_port,
    output logic [15:0] o_dest_port,
    output logic [31:0] o_sequence_res,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_length,
    output logic        o_handshake_start
);
    logic [2:0] link_kind;
    logic take, done;
    cfthp_pkg::t_result res, r_res;
    logic r_valid;

    cfthp_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_link_kind(link_kind)
    );

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    cfthp_parse #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parse (
        .i_clk, .i_rst_n, .i_take(take), .i_byte(i_frame_byte), .i_end(i_frame_end),
        .i_link_kind(link_kind), .o_done(done), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_res <= res;
        end
    end

    assign o_valid            = r_valid;
    assign o_verdict          = r_res.verdict;
    assign o_ip_ver           = r_res.ip_ver;
    assign o_source_addr_high = r_res.sa_hi;
    assign o_source_addr_low  = r_res.sa_lo;
    assign o_dest_addr_high   = r_res.da_hi;
    assign o_dest_addr_low    = r_res.da_lo;
    assign o_source_port      = r_res.sport;
    assign o_dest_port        = r_res.dport;
    assign o_sequence_res     = r_res.seq;
    assign o_payload_offset   = r_res.off;
    assign o_payload_length   = r_res.plen;
    assign o_handshake_start  = r_res.hs;

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("result overwritten while stalled");
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_frame_end) |=> o_valid)
        else $error("frame end without result");
    a_hs_needs_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_handshake_start) |-> (o_verdict == cfthp_pkg::V_TCP))
        else $error("handshake flag without payload");
endmodule

/* tb/tb_capture_frame_tcp_header_parser.sv */
// testbench: captured frames byte by byte through the tcp header parser, checked by a predictor
`timescale 1ns / 1ps

module tb_capture_frame_tcp_header_parser;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 1300;
    localparam logic [7:0] CCS_HEAD [5] = '{8'h14, 8'h03, 8'h03, 8'h00, 8'h01};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_frame_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    cfthp_pkg::t_result got;

    capture_frame_tcp_header_parser i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_frame_byte(i_frame_byte), .i_frame_end(i_frame_end),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_verdict(got.verdict), .o_ip_ver(got.ip_ver),
        .o_source_addr_high(got.sa_hi), .o_source_addr_low(got.sa_lo),
        .o_dest_addr_high(got.da_hi), .o_dest_addr_low(got.da_lo),
        .o_source_port(got.sport), .o_dest_port(got.dport),
        .o_sequence_res(got.seq), .o_payload_offset(got.off),
        .o_payload_length(got.plen), .o_handshake_start(got.hs)
    );

    always #5 i_clk = ~i_clk;

    // parser shadow state
    logic [2:0]  link_cfg;
    logic [2:0]  frame_link;
    cfthp_pkg::t_phase phase;
    int unsigned pos, sec_start, sec_len;
    logic [15:0] ether_type;
    logic [7:0]  next_hdr;
    logic [63:0] addr [4];
    logic [63:0] port_seq;
    int unsigned ccs_state;
    logic [2:0]  fault;
    logic [2:0]  ip_ver;
    logic        hs_first, hs_seventh;

    cfthp_pkg::t_result verdict_q [$];
    logic [7:0]  frame_buf [$];
    int          errors = 0;
    int          n_bytes = 0;
    int          n_results = 0;
    int          n_frames = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    function automatic void clear_frame();
        phase = cfthp_pkg::PH_LINK;
        pos = 0; sec_start = 0; sec_len = 0;
        ether_type = '0; next_hdr = '0;
        for (int k = 0; k < 4; k++) addr[k] = '0;
        port_seq = '0; ccs_state = 0; fault = '0;
        frame_link = '0; ip_ver = '0;
        hs_first = 1'b0; hs_seventh = 1'b0;
    endfunction

    function automatic void enter_section(cfthp_pkg::t_phase ph, int unsigned st,
                                          int unsigned len);
        phase = ph;
        sec_start = st;
        sec_len = len;
        if (ph == cfthp_pkg::PH_IP4) ip_ver = 3'd4;
        if (ph == cfthp_pkg::PH_IP6) ip_ver = 3'd6;
    endfunction

    function automatic void pick_network(int unsigned p);
        if (frame_link == cfthp_pkg::LK_ETH &&
            (ether_type == cfthp_pkg::ET_VLAN || ether_type == cfthp_pkg::ET_QINQ))
            enter_section(cfthp_pkg::PH_VLAN, p + 1, 4);
        else if (ether_type == cfthp_pkg::ET_IP4)
            enter_section(cfthp_pkg::PH_IP4, p + 1, 20);
        else if (ether_type == cfthp_pkg::ET_IP6)
            enter_section(cfthp_pkg::PH_IP6, p + 1, 40);
        else
            fault = cfthp_pkg::V_NOT_IP;
    endfunction

    function automatic void follow_ip6_chain(int unsigned p);
        if (next_hdr == cfthp_pkg::NH_HOP || next_hdr == cfthp_pkg::NH_ROUTE)
            enter_section(cfthp_pkg::PH_EXT, p + 1, 8);
        else if (next_hdr != cfthp_pkg::NH_TCP)
            fault = cfthp_pkg::V_NOT_TCP;
        else
            enter_section(cfthp_pkg::PH_TCP, p + 1, 20);
    endfunction

    function automatic void parse_byte(logic [7:0] b, int unsigned p);
        int unsigned rel;
        int unsigned k;
        rel = p - sec_start;
        case (phase)
            cfthp_pkg::PH_LINK: begin
                if (frame_link == cfthp_pkg::LK_ETH) begin
                    if (rel == 12) ether_type = {b, 8'h00};
                    if (rel == 13) begin
                        ether_type[7:0] = b;
                        pick_network(p);
                    end
                end else if (frame_link == cfthp_pkg::LK_SLL2) begin
                    if (rel == 0) ether_type = {b, 8'h00};
                    if (rel == 1) ether_type[7:0] = b;
                    if (rel == 19) pick_network(p);
                end else if (frame_link == cfthp_pkg::LK_SLL) begin
                    if (rel == 14) ether_type = {b, 8'h00};
                    if (rel == 15) begin
                        ether_type[7:0] = b;
                        pick_network(p);
                    end
                end else begin
                    if (rel == 0) ether_type = (b == 8'd2) ? cfthp_pkg::ET_IP4 : cfthp_pkg::ET_IP6;
                    else if (b != 8'd0) ether_type = cfthp_pkg::ET_IP6;
                    if (rel == 3) pick_network(p);
                end
            end
            cfthp_pkg::PH_VLAN: begin
                if (rel == 2) ether_type = {b, 8'h00};
                if (rel == 3) begin
                    ether_type[7:0] = b;
                    pick_network(p);
                end
            end
            cfthp_pkg::PH_IP4: begin
                if (rel == 0) begin
                    if (b[7:4] != 4'd4) begin
                        fault = cfthp_pkg::V_NOT_IP;
                        return;
                    end
                    sec_len = b[3:0] * 4;
                    if (sec_len < 20) begin
                        fault = cfthp_pkg::V_BAD_HLEN;
                        return;
                    end
                end
                if (rel == 9 && b != cfthp_pkg::NH_TCP) begin
                    fault = cfthp_pkg::V_NOT_TCP;
                    return;
                end
                if (rel >= 12 && rel < 16) addr[1] = {32'd0, addr[1][23:0], b};
                if (rel >= 16 && rel < 20) addr[3] = {32'd0, addr[3][23:0], b};
                if (rel + 1 == sec_len) enter_section(cfthp_pkg::PH_TCP, p + 1, 20);
            end
            cfthp_pkg::PH_IP6: begin
                if (rel == 0 && b[7:4] != 4'd6) begin
                    fault = cfthp_pkg::V_NOT_IP;
                    return;
                end
                if (rel == 6) next_hdr = b;
                if (rel >= 8 && rel < 40) begin
                    k = ((rel - 8) >> 3) & 3;
                    addr[k] = {addr[k][55:0], b};
                end
                if (rel == 39) follow_ip6_chain(p);
            end
            cfthp_pkg::PH_EXT: begin
                if (rel == 0) next_hdr = b;
                if (rel == 1) sec_len = (b + 1) * 8;
                if (rel + 1 == sec_len) follow_ip6_chain(p);
            end
            cfthp_pkg::PH_TCP: begin
                if (rel < 8) port_seq = {port_seq[55:0], b};
                if (rel == 12) begin
                    sec_len = b[7:4] * 4;
                    if (sec_len < 20) begin
                        fault = cfthp_pkg::V_BAD_HLEN;
                        return;
                    end
                end
                if (rel + 1 == sec_len) begin
                    enter_section(cfthp_pkg::PH_PAY, p + 1, 0);
                    ccs_state = 0;
                end
            end
            default: begin
                if (rel < 5) begin
                    if (ccs_state == rel && b == CCS_HEAD[rel]) ccs_state = rel + 1;
                    else ccs_state = 7;
                end
                if (rel == 0) hs_first = (b == cfthp_pkg::TLS_HS);
                if (rel == 6) hs_seventh = (b == cfthp_pkg::TLS_HS);
            end
        endcase
    endfunction

    // advance the shadow parser by one accepted byte; queue a verdict at frame end
    function automatic void predict_byte(logic [7:0] b, logic last);
        cfthp_pkg::t_result r;
        int unsigned plen, off;
        logic [31:0] seq;
        logic hs;
        if (pos < cfthp_pkg::MAX_FRAME_BYTES) begin
            if (pos == 0) begin
                frame_link = link_cfg;
                if (frame_link > cfthp_pkg::LK_RAW) fault = cfthp_pkg::V_BAD_LINK;
                else if (frame_link == cfthp_pkg::LK_RAW) begin
                    if (b[7:4] == 4'd4) enter_section(cfthp_pkg::PH_IP4, 0, 20);
                    else enter_section(cfthp_pkg::PH_IP6, 0, 40);
                end
            end
            if (fault == '0) parse_byte(b, pos);
            pos++;
        end
        if (!last) return;
        r = '0;
        if (fault != '0) r.verdict = fault;
        else if (phase != cfthp_pkg::PH_PAY) r.verdict = cfthp_pkg::V_TRUNC;
        else begin
            plen = pos - sec_start;
            off = sec_start;
            seq = port_seq[31:0];
            hs = hs_first;
            if (plen >= 6 && ccs_state == 5) begin
                plen -= 6;
                off += 6;
                seq += 32'd6;
                hs = hs_seventh;
            end
            r.verdict = (plen == 0) ? cfthp_pkg::V_NO_PAY : cfthp_pkg::V_TCP;
            r.ip_ver = ip_ver;
            r.sa_hi = addr[0];
            r.sa_lo = addr[1];
            r.da_hi = addr[2];
            r.da_lo = addr[3];
            r.sport = port_seq[63:48];
            r.dport = port_seq[47:32];
            r.seq = seq;
            r.off = off[15:0];
            r.plen = plen[15:0];
            r.hs = (plen != 0) && hs;
        end
        verdict_q.push_back(r);
        clear_frame();
    endfunction

    task automatic report(string field, logic [63:0] exp_v, logic [63:0] got_v);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, field, exp_v, got_v);
        errors++;
    endtask

    task automatic check_result(cfthp_pkg::t_result g);
        cfthp_pkg::t_result e;
        if (verdict_q.size() == 0) begin
            report("unexpected result verdict", '0, g.verdict);
            return;
        end
        e = verdict_q.pop_front();
        n_results++;
        if (g.verdict !== e.verdict) report("verdict", e.verdict, g.verdict);
        if (g.ip_ver !== e.ip_ver) report("ip_ver", e.ip_ver, g.ip_ver);
        if (g.sa_hi !== e.sa_hi) report("source_addr_high", e.sa_hi, g.sa_hi);
        if (g.sa_lo !== e.sa_lo) report("source_addr_low", e.sa_lo, g.sa_lo);
        if (g.da_hi !== e.da_hi) report("dest_addr_high", e.da_hi, g.da_hi);
        if (g.da_lo !== e.da_lo) report("dest_addr_low", e.da_lo, g.da_lo);
        if (g.sport !== e.sport) report("source_port", e.sport, g.sport);
        if (g.dport !== e.dport) report("dest_port", e.dport, g.dport);
        if (g.seq !== e.seq) report("sequence_res", e.seq, g.seq);
        if (g.off !== e.off) report("payload_offset", e.off, g.off);
        if (g.plen !== e.plen) report("payload_length", e.plen, g.plen);
        if (g.hs !== e.hs) report("handshake_start", e.hs, g.hs);
    endtask

    // result side: check, then random stall bursts or a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) check_result(got);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame_byte <= b;
        i_frame_end <= last;
        do @(posedge i_clk); while (o_stall);
        predict_byte(b, last);
        n_bytes++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_link(logic [2:0] kind);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= cfthp_pkg::REG_LINK_KIND;
        pwdata <= {29'd0, kind};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        link_cfg = kind;
    endtask

    task automatic push_rand(int count);
        repeat (count) frame_buf.push_back(8'($urandom));
    endtask

    task automatic push_type(logic [15:0] et);
        frame_buf.push_back(et[15:8]);
        frame_buf.push_back(et[7:0]);
    endtask

    // mostly well-formed link/ip/tcp frames with random content, some broken
    task automatic build_frame(logic [2:0] kind);
        bit v6;
        logic [15:0] et;
        int n_ext, ihl, doff, mode, cut;
        logic [7:0] nh;
        frame_buf.delete();
        v6 = $urandom_range(0, 1);
        et = v6 ? cfthp_pkg::ET_IP6 : cfthp_pkg::ET_IP4;
        if ($urandom_range(0, 19) == 0) et = 16'($urandom);
        case (kind)
            cfthp_pkg::LK_ETH: begin
                push_rand(12);
                repeat ($urandom_range(0, 2)) begin
                    push_type($urandom_range(0, 1) ? cfthp_pkg::ET_VLAN : cfthp_pkg::ET_QINQ);
                    push_rand(2);
                end
                push_type(et);
            end
            cfthp_pkg::LK_SLL2: begin
                push_type(et);
                push_rand(18);
            end
            cfthp_pkg::LK_SLL: begin
                push_rand(14);
                push_type(et);
            end
            cfthp_pkg::LK_NULL: begin
                frame_buf.push_back(v6 ? 8'(24 + 2 * $urandom_range(0, 3)) : 8'd2);
                repeat (3) frame_buf.push_back(8'd0);
            end
            cfthp_pkg::LK_RAW: ;
            default: push_rand($urandom_range(0, 20));
        endcase
        if (!v6) begin
            ihl = $urandom_range(5, 7);
            frame_buf.push_back({4'd4, 4'(ihl)});
            push_rand(8);
            frame_buf.push_back($urandom_range(0, 19) == 0 ? 8'($urandom) : cfthp_pkg::NH_TCP);
            push_rand(10 + (ihl - 5) * 4);
        end else begin
            n_ext = $urandom_range(0, 2);
            frame_buf.push_back({4'd6, 4'($urandom)});
            push_rand(5);
            nh = (n_ext == 0) ? cfthp_pkg::NH_TCP :
                 ($urandom_range(0, 1) ? cfthp_pkg::NH_HOP : cfthp_pkg::NH_ROUTE);
            frame_buf.push_back(nh);
            push_rand(33);
            for (int k = 0; k < n_ext; k++) begin
                int l;
                l = $urandom_range(0, 1);
                if (k == n_ext - 1) nh = ($urandom_range(0, 19) == 0) ? 8'd17 : cfthp_pkg::NH_TCP;
                else nh = $urandom_range(0, 1) ? cfthp_pkg::NH_HOP : cfthp_pkg::NH_ROUTE;
                frame_buf.push_back(nh);
                frame_buf.push_back(8'(l));
                push_rand((l + 1) * 8 - 2);
            end
        end
        doff = $urandom_range(4, 8);
        push_rand(12);
        frame_buf.push_back({4'(doff), 4'($urandom)});
        push_rand(7 + (doff > 5 ? (doff - 5) * 4 : 0));
        mode = $urandom_range(0, 3);
        if (mode == 1) begin
            foreach (CCS_HEAD[k]) frame_buf.push_back(CCS_HEAD[k]);
            push_rand(1);
            if ($urandom_range(0, 1)) frame_buf.push_back(cfthp_pkg::TLS_HS);
            push_rand($urandom_range(0, 10));
        end else if (mode >= 2) begin
            if (mode == 2) frame_buf.push_back(cfthp_pkg::TLS_HS);
            push_rand($urandom_range(1, 20));
        end
        case ($urandom_range(0, 9))
            0: begin
                cut = $urandom_range(1, frame_buf.size());
                while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            end
            1: frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
            2: begin
                frame_buf.delete();
                push_rand($urandom_range(1, 40));
            end
            default: ;
        endcase
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_byte(frame_buf[k], k == frame_buf.size() - 1);
        n_frames++;
    endtask

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        bit         typed;
        logic [2:0] verdict;
    } t_stim_row;

    t_stim_row stim_table [] = '{
        '{3'd5, 8'h00, 1'b1, 1'b1, cfthp_pkg::V_BAD_LINK},
        '{3'd7, 8'hFF, 1'b1, 1'b1, cfthp_pkg::V_BAD_LINK},
        '{cfthp_pkg::LK_RAW, 8'h45, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_RAW, 8'h41, 1'b1, 1'b1, cfthp_pkg::V_BAD_HLEN},
        '{cfthp_pkg::LK_RAW, 8'h4F, 1'b0, 1'b0, cfthp_pkg::V_TCP},
        '{cfthp_pkg::LK_RAW, 8'h00, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_RAW, 8'h75, 1'b1, 1'b1, cfthp_pkg::V_NOT_IP},
        '{cfthp_pkg::LK_RAW, 8'h00, 1'b1, 1'b1, cfthp_pkg::V_NOT_IP},
        '{cfthp_pkg::LK_RAW, 8'h60, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_NULL, 8'h02, 1'b0, 1'b0, cfthp_pkg::V_TCP},
        '{cfthp_pkg::LK_NULL, 8'h00, 1'b0, 1'b0, cfthp_pkg::V_TCP},
        '{cfthp_pkg::LK_NULL, 8'h00, 1'b0, 1'b0, cfthp_pkg::V_TCP},
        '{cfthp_pkg::LK_NULL, 8'h00, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_ETH, 8'hFF, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_SLL2, 8'h86, 1'b1, 1'b1, cfthp_pkg::V_TRUNC},
        '{cfthp_pkg::LK_SLL, 8'h80, 1'b1, 1'b1, cfthp_pkg::V_TRUNC}
    };

    initial begin
        cfthp_pkg::t_result typed_res;
        logic [2:0] kind;
        link_cfg = cfthp_pkg::LK_ETH;
        clear_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[k]) begin
            if (stim_table[k].kind != link_cfg || k == 0) set_link(stim_table[k].kind);
            send_byte(stim_table[k].data, stim_table[k].last);
            if (stim_table[k].typed) begin
                void'(verdict_q.pop_back());
                typed_res = '0;
                typed_res.verdict = stim_table[k].verdict;
                verdict_q.push_back(typed_res);
            end
        end

        while (n_bytes < RANDOM_BYTES) begin
            kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            if (kind != link_cfg) set_link(kind);
            if (n_frames == 5) begin
                // long hold on results while requests keep coming
                hold_left = 300;
                repeat (8) begin
                    build_frame(kind);
                    send_frame();
                end
                drain();
            end
            build_frame(kind);
            if (n_bytes > RANDOM_BYTES - 300) quiet = 1'b1;
            send_frame();
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d frames, %0d bytes, %0d verdicts checked", n_frames, n_bytes,
                 n_results);
        $display("link kinds 0 to 7, vlan tags, ipv6 extensions, cipher spec strip, stalls");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
